>>> sv/gzhp_pkg.sv
// Shared types and constants for the gzip member header parser.
// No dependencies.
package gzhp_pkg;

  typedef enum logic [3:0] {
    PH_FIXED   = 4'd0,
    PH_XLEN0   = 4'd1,
    PH_XLEN1   = 4'd2,
    PH_EXTRA   = 4'd3,
    PH_NAME    = 4'd4,
    PH_COMMENT = 4'd5,
    PH_HCRC0   = 4'd6,
    PH_HCRC1   = 4'd7,
    PH_BODY    = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ST_HEADER = 3'd0,
    ST_DONE   = 3'd1,
    ST_MAGIC  = 3'd2,
    ST_METHOD = 3'd3,
    ST_CRC    = 3'd4,
    ST_BODY   = 3'd5
  } status_t;

  // flag bit positions
  localparam int unsigned FL_TEXT    = 0;
  localparam int unsigned FL_HCRC    = 1;
  localparam int unsigned FL_EXTRA   = 2;
  localparam int unsigned FL_NAME    = 3;
  localparam int unsigned FL_COMMENT = 4;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [7:0]  ID1        = 8'h1F;
  localparam logic [7:0]  ID2        = 8'h8B;
  localparam logic [7:0]  CM_DEFLATE = 8'd8;
  localparam logic [3:0]  FIX_FLG    = 4'd3;
  localparam logic [3:0]  FIX_LAST   = 4'd9;

  typedef struct packed {
    status_t     status;
    logic [7:0]  body_byte;
    logic        body_valid;
    logic        text_hint;
  } result_t;

endpackage

>>> sv/gzhp_crc_byte.sv
// Byte-wide update of the reflected CRC-32 register.
// Depends on gzhp_pkg.
module gzhp_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);
  import gzhp_pkg::*;

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

>>> sv/gzhp_core.sv
// Header parse state and per-beat step logic.
// Depends on gzhp_pkg and gzhp_crc_byte.
module gzhp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               start_member,
  output gzhp_pkg::result_t  res
);
  import gzhp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;
  logic [4:0]  flags_r, flags_nxt;
  logic [15:0] xrem_r, xrem_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [7:0]  crclo_r, crclo_nxt;
  status_t     err_r, err_nxt;

  phase_t      ph_e;
  logic [3:0]  fcnt_e;
  logic [4:0]  flags_e;
  logic [15:0] xrem_e;
  logic [31:0] crc_e, crc_upd, crc_fin;
  logic [7:0]  crclo_e;
  status_t     err_e;

  function automatic phase_t next_phase(phase_t after, logic [4:0] fl);
    phase_t p;
    p = PH_BODY;
    if (after < PH_HCRC0 && fl[FL_HCRC])    p = PH_HCRC0;
    if (after < PH_COMMENT && fl[FL_COMMENT]) p = PH_COMMENT;
    if (after < PH_NAME && fl[FL_NAME])      p = PH_NAME;
    if (after < PH_XLEN0 && fl[FL_EXTRA])    p = PH_XLEN0;
    return p;
  endfunction

  // start mark resets the parser before this beat is taken
  always_comb begin
    ph_e    = start_member ? PH_FIXED : phase_r;
    fcnt_e  = start_member ? 4'd0 : fcnt_r;
    flags_e = start_member ? 5'd0 : flags_r;
    xrem_e  = start_member ? 16'd0 : xrem_r;
    crc_e   = start_member ? CRC_INIT : crc_r;
    crclo_e = start_member ? 8'd0 : crclo_r;
    err_e   = start_member ? ST_HEADER : err_r;
  end

  gzhp_crc_byte u_crc (
    .crc_in  (crc_e),
    .data    (data_byte),
    .crc_out (crc_upd)
  );

  assign crc_fin = ~crc_e;

  always_comb begin
    status_t st;
    phase_t  np;
    logic [15:0] xdec;
    phase_nxt = ph_e;
    fcnt_nxt  = fcnt_e;
    flags_nxt = flags_e;
    xrem_nxt  = xrem_e;
    crc_nxt   = crc_e;
    crclo_nxt = crclo_e;
    err_nxt   = err_e;
    st        = ST_HEADER;
    np        = PH_BODY;
    xdec      = xrem_e - 16'd1;
    res.body_byte  = 8'd0;
    res.body_valid = 1'b0;

    if (err_e != ST_HEADER) begin
      st = err_e;
    end else if (ph_e < PH_HCRC0) begin
      crc_nxt = crc_upd;
      case (ph_e)
        PH_FIXED: begin
          fcnt_nxt = fcnt_e + 4'd1;
          if (fcnt_e == 4'd0 && data_byte != ID1) begin
            st = ST_MAGIC;
          end else if (fcnt_e == 4'd1 && data_byte != ID2) begin
            st = ST_MAGIC;
          end else if (fcnt_e == 4'd2 && data_byte != CM_DEFLATE) begin
            st = ST_METHOD;
          end else if (fcnt_e == FIX_FLG) begin
            flags_nxt = data_byte[4:0];
          end else if (fcnt_e >= FIX_LAST) begin
            np = next_phase(PH_FIXED, flags_e);
            phase_nxt = np;
            st = (np == PH_BODY) ? ST_DONE : ST_HEADER;
          end
          if (st == ST_MAGIC || st == ST_METHOD) err_nxt = st;
        end
        PH_XLEN0: begin
          xrem_nxt  = {8'd0, data_byte};
          phase_nxt = PH_XLEN1;
        end
        PH_XLEN1: begin
          xrem_nxt = {data_byte, xrem_e[7:0]};
          if ({data_byte, xrem_e[7:0]} == 16'd0) begin
            np = next_phase(PH_EXTRA, flags_e);
            phase_nxt = np;
            st = (np == PH_BODY) ? ST_DONE : ST_HEADER;
          end else begin
            phase_nxt = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          xrem_nxt = xdec;
          if (xdec == 16'd0) begin
            np = next_phase(PH_EXTRA, flags_e);
            phase_nxt = np;
            st = (np == PH_BODY) ? ST_DONE : ST_HEADER;
          end
        end
        PH_NAME, PH_COMMENT: begin
          if (data_byte == 8'd0) begin
            np = next_phase(ph_e, flags_e);
            phase_nxt = np;
            st = (np == PH_BODY) ? ST_DONE : ST_HEADER;
          end
        end
        default: ;
      endcase
    end else if (ph_e == PH_HCRC0) begin
      crclo_nxt = data_byte;
      phase_nxt = PH_HCRC1;
    end else if (ph_e == PH_HCRC1) begin
      if (crc_fin[7:0] == crclo_e && crc_fin[15:8] == data_byte) begin
        st = ST_DONE;
        phase_nxt = PH_BODY;
      end else begin
        st = ST_CRC;
        err_nxt = ST_CRC;
      end
    end else begin
      st = ST_BODY;
      res.body_byte  = data_byte;
      res.body_valid = 1'b1;
    end

    res.status    = st;
    res.text_hint = flags_nxt[FL_TEXT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIXED;
      fcnt_r  <= 4'd0;
      flags_r <= 5'd0;
      xrem_r  <= 16'd0;
      crc_r   <= CRC_INIT;
      crclo_r <= 8'd0;
      err_r   <= ST_HEADER;
    end else if (step) begin
      phase_r <= phase_nxt;
      fcnt_r  <= fcnt_nxt;
      flags_r <= flags_nxt;
      xrem_r  <= xrem_nxt;
      crc_r   <= crc_nxt;
      crclo_r <= crclo_nxt;
      err_r   <= err_nxt;
    end
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    step && !start_member && err_r != ST_HEADER |=> err_r == $past(err_r))
    else $error("sticky error changed without start mark");

  a_body_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> err_r == ST_HEADER)
    else $error("body phase with error latched");

  a_err_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(crc_r))
    else $error("parse state moved without a beat");

endmodule

>>> sv/gzip_header_parser.sv
// Top level: input register, header parse step, result register.
// An input beat goes through the input register, then the result register; one beat per cycle while out_ready holds.
// Throughput is set by the combinational parse step (byte-wide CRC update).
// Synchronous active-low reset: both stages empty, parser waits for ID1.
// Depends on gzhp_pkg, gzhp_core.
module gzip_header_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_member,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_body_byte,
  output logic       out_body_valid,
  output logic       out_text_hint
);
  import gzhp_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       out_valid_r;
  result_t    out_r;
  result_t    res;
  logic       adv;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_start_member;
    end
  end

  gzhp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .data_byte    (s1_byte_r),
    .start_member (s1_start_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_body_byte  = out_r.body_byte;
  assign out_body_valid = out_r.body_valid;
  assign out_text_hint  = out_r.text_hint;

  a_body_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.body_valid |-> out_r.status == ST_BODY)
    else $error("body flag without body status");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r)
    else $error("pending beat dropped under stall");

endmodule

>>> tb/sv/gzip_header_parser_tb.sv
// Self-checking testbench for gzip_header_parser: gzip member streams go in, one status beat
// per byte comes out and is checked against an in-bench header parser model.
// Depends on gzhp_pkg and the gzip_header_parser RTL.
`timescale 1ns / 100ps

module gzip_header_parser_tb;
  import gzhp_pkg::*;

  localparam int RANDOM_BEATS = 1100;
  localparam int SHOWN_ERRORS = 10;
  localparam int CRC_OK       = 0;
  localparam int CRC_BAD_LO   = 1;
  localparam int CRC_BAD_HI   = 2;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_start_member = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_body_byte;
  logic       out_body_valid;
  logic       out_text_hint;

  gzip_header_parser u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_start_member (in_start_member),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_body_byte   (out_body_byte),
    .out_body_valid  (out_body_valid),
    .out_text_hint   (out_text_hint)
  );

  always #5 clk = ~clk;

  // parser model state
  phase_t      ph;
  logic [3:0]  fix_cnt;
  logic [4:0]  flg;
  logic [15:0] xrem;
  logic [31:0] crc_reg;
  logic [7:0]  crc_lo;
  status_t     err;

  result_t     status_q[$];
  logic [7:0]  member_q[$];

  int  n_beats = 0;
  int  n_results = 0;
  int  n_mismatch = 0;
  int  n_unexpected = 0;
  int  n_members = 0;
  int  seen[6];
  int  burst_left = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  logic [15:0] rx_mask = 16'h5A5B;
  logic [3:0]  rx_pos = 4'd0;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'd0, d};
    for (int k = 0; k < 8; k++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void clear_parser();
    ph      = PH_FIXED;
    fix_cnt = 4'd0;
    flg     = 5'd0;
    xrem    = 16'd0;
    crc_reg = CRC_INIT;
    crc_lo  = 8'd0;
    err     = ST_HEADER;
  endfunction

  // picks the next optional section the flags ask for
  function automatic status_t advance_phase(input phase_t after);
    if (after < PH_XLEN0 && flg[FL_EXTRA]) ph = PH_XLEN0;
    else if (after < PH_NAME && flg[FL_NAME]) ph = PH_NAME;
    else if (after < PH_COMMENT && flg[FL_COMMENT]) ph = PH_COMMENT;
    else if (after < PH_HCRC0 && flg[FL_HCRC]) ph = PH_HCRC0;
    else ph = PH_BODY;
    return (ph == PH_BODY) ? ST_DONE : ST_HEADER;
  endfunction

  function automatic result_t parse_status(input logic [7:0] d, input logic s);
    result_t     r;
    status_t     st;
    logic [31:0] fin;
    if (s) clear_parser();
    st = ST_HEADER;
    r.body_byte = 8'd0;
    r.body_valid = 1'b0;
    if (err != ST_HEADER) begin
      st = err;
    end else if (ph < PH_HCRC0) begin
      crc_reg = crc_byte(crc_reg, d);
      case (ph)
        PH_FIXED: begin
          if (fix_cnt == 4'd0 && d != ID1) st = ST_MAGIC;
          else if (fix_cnt == 4'd1 && d != ID2) st = ST_MAGIC;
          else if (fix_cnt == 4'd2 && d != CM_DEFLATE) st = ST_METHOD;
          else if (fix_cnt == FIX_FLG) flg = d[4:0];
          else if (fix_cnt >= FIX_LAST) st = advance_phase(PH_FIXED);
          fix_cnt = fix_cnt + 4'd1;
          if (st == ST_MAGIC || st == ST_METHOD) err = st;
        end
        PH_XLEN0: begin
          xrem = {8'd0, d};
          ph = PH_XLEN1;
        end
        PH_XLEN1: begin
          xrem = {d, xrem[7:0]};
          if (xrem == 16'd0) st = advance_phase(PH_EXTRA);
          else ph = PH_EXTRA;
        end
        PH_EXTRA: begin
          xrem = xrem - 16'd1;
          if (xrem == 16'd0) st = advance_phase(PH_EXTRA);
        end
        PH_NAME: begin
          if (d == 8'd0) st = advance_phase(PH_NAME);
        end
        default: begin
          if (d == 8'd0) st = advance_phase(PH_COMMENT);
        end
      endcase
    end else if (ph == PH_HCRC0) begin
      crc_lo = d;
      ph = PH_HCRC1;
    end else if (ph == PH_HCRC1) begin
      fin = ~crc_reg;
      if (fin[7:0] == crc_lo && fin[15:8] == d) begin
        st = ST_DONE;
        ph = PH_BODY;
      end else begin
        st = ST_CRC;
        err = ST_CRC;
      end
    end else begin
      st = ST_BODY;
      r.body_byte = d;
      r.body_valid = 1'b1;
    end
    r.status = st;
    r.text_hint = flg[FL_TEXT];
    return r;
  endfunction

  // one input beat; called at a rising edge, returns at the edge that accepts it
  task automatic send_beat(input logic [7:0] d, input logic s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = tx_idle_en ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_data_byte    <= d;
    in_start_member <= s;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    n_beats++;
    status_q.push_back(parse_status(d, s));
  endtask

  task automatic build_member(input logic [7:0] flags, input int xlen, input int name_len,
                              input int cmt_len, input int crc_fault, input int body_len,
                              input int fill);
    logic [31:0] c;
    logic [7:0]  lo, hi;
    member_q = {};
    member_q.push_back(ID1);
    member_q.push_back(ID2);
    member_q.push_back(CM_DEFLATE);
    member_q.push_back(flags);
    repeat (6) member_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    if (flags[FL_EXTRA]) begin
      member_q.push_back(xlen[7:0]);
      member_q.push_back(xlen[15:8]);
      repeat (xlen) member_q.push_back(8'($urandom));
    end
    if (flags[FL_NAME]) begin
      repeat (name_len) member_q.push_back(8'($urandom_range(1, 255)));
      member_q.push_back(8'd0);
    end
    if (flags[FL_COMMENT]) begin
      repeat (cmt_len) member_q.push_back(8'($urandom_range(1, 255)));
      member_q.push_back(8'd0);
    end
    if (flags[FL_HCRC]) begin
      c = CRC_INIT;
      foreach (member_q[i]) c = crc_byte(c, member_q[i]);
      c = ~c;
      lo = c[7:0];
      hi = c[15:8];
      if (crc_fault == CRC_BAD_LO) lo = lo ^ (8'd1 << $urandom_range(0, 7));
      if (crc_fault == CRC_BAD_HI) hi = hi ^ (8'd1 << $urandom_range(0, 7));
      member_q.push_back(lo);
      member_q.push_back(hi);
    end
    repeat (body_len) member_q.push_back(8'($urandom));
  endtask

  task automatic send_member(input bit mark);
    foreach (member_q[i]) send_beat(member_q[i], mark && i == 0);
    n_members++;
  endtask

  // result side: check accepted beats, then set next ready
  always @(posedge clk) begin : rx_check
    result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.status     = status_t'(out_status);
      got.body_byte  = out_body_byte;
      got.body_valid = out_body_valid;
      got.text_hint  = out_text_hint;
      n_results++;
      if (out_status < 3'd6) seen[out_status]++;
      if (status_q.size() == 0) begin
        n_unexpected++;
        if (n_mismatch + n_unexpected <= SHOWN_ERRORS)
          $display("result %0d: no beat expected, got status=%0d byte=%02h bv=%0b txt=%0b",
                   n_results, out_status, out_body_byte, out_body_valid, out_text_hint);
      end else begin
        want = status_q.pop_front();
        if (got.status != want.status || got.body_byte != want.body_byte ||
            got.body_valid != want.body_valid || got.text_hint != want.text_hint) begin
          n_mismatch++;
          if (n_mismatch + n_unexpected <= SHOWN_ERRORS)
            $display("result %0d: exp status=%0d byte=%02h bv=%0b txt=%0b,",
                     n_results, want.status, want.body_byte, want.body_valid, want.text_hint,
                     " got status=%0d byte=%02h bv=%0b txt=%0b",
                     out_status, out_body_byte, out_body_valid, out_text_hint);
        end
      end
    end
    out_ready <= !rx_idle_en || rx_mask[rx_pos];
    rx_pos <= rx_pos + 4'd1;
    if (rx_pos == 4'd15 && $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: rx_mask <= 16'($urandom & $urandom) | 16'd1;
        1: rx_mask <= 16'($urandom | $urandom);
        default: rx_mask <= 16'($urandom) | 16'd1;
      endcase
    end
  end

  // no start mark after reset: the first byte is ID1
  task automatic test_no_start_mark();
    build_member(8'h00, 0, 0, 0, CRC_OK, 3, -1);
    send_member(1'b0);
  endtask

  task automatic test_fixed_fields();
    // reserved flag bits set, FTEXT set, all-ones mtime/xfl/os
    build_member(8'hE1, 0, 0, 0, CRC_OK, 0, 8'hFF);
    member_q.push_back(8'h00);
    member_q.push_back(8'hFF);
    send_member(1'b1);
    build_member(8'h00, 0, 0, 0, CRC_OK, 1, 8'h00);
    send_member(1'b1);
  endtask

  task automatic test_bad_header();
    member_q = {8'h00, 8'h8B, 8'h08};
    send_member(1'b1);
    member_q = {ID1, 8'h1E, 8'hFF};
    send_member(1'b1);
    member_q = {ID1, ID2, 8'h07, 8'h00, 8'h1F};
    send_member(1'b1);
  endtask

  task automatic test_optional_fields();
    build_member(8'h1F, 0, 2, 1, CRC_OK, 2, -1);
    send_member(1'b1);
    build_member(8'h04, 3, 0, 0, CRC_OK, 1, -1);
    send_member(1'b1);
    build_member(8'h18, 0, 0, 0, CRC_OK, 1, -1);
    send_member(1'b1);
    build_member(8'h02, 0, 0, 0, CRC_BAD_LO, 2, -1);
    send_member(1'b1);
    build_member(8'h0A, 0, 1, 0, CRC_BAD_HI, 2, -1);
    send_member(1'b1);
  endtask

  // extra field lengths that walk the upper bits of the length counter
  task automatic test_long_extra();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    build_member(8'h06, 16'h0100, 0, 0, CRC_OK, 1, -1);
    send_member(1'b1);
    build_member(8'h04, 16'h0201, 0, 0, CRC_OK, 2, -1);
    send_member(1'b1);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_random_members();
    int first_beat, pick, idx, cut;
    logic [7:0] flags;
    first_beat = n_beats;
    while (n_beats - first_beat < RANDOM_BEATS) begin
      tx_idle_en = ($urandom_range(0, 7) != 0);
      rx_idle_en = ($urandom_range(0, 7) != 0);
      pick  = $urandom_range(0, 99);
      flags = 8'($urandom);
      if (pick < 8) flags[FL_HCRC] = 1'b1;
      if (pick >= 18 && pick < 23) begin
        repeat ($urandom_range(1, 20))
          send_beat(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        build_member(flags,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(9, 300) : $urandom_range(0, 8),
                     $urandom_range(0, 6), $urandom_range(0, 6),
                     (pick < 8) ? $urandom_range(CRC_BAD_LO, CRC_BAD_HI) : CRC_OK,
                     $urandom_range(0, 12), -1);
        if (pick >= 8 && pick < 14) begin
          idx = $urandom_range(0, 2);
          member_q[idx] = member_q[idx] ^ 8'($urandom_range(1, 255));
        end
        if (pick >= 14 && pick < 18) begin
          cut = $urandom_range(1, member_q.size() - 1);
          repeat (cut) void'(member_q.pop_back());
        end
        send_member($urandom_range(0, 19) != 0);
      end
    end
  endtask

  initial begin : main
    int leftover;
    clear_parser();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_no_start_mark();
    test_fixed_fields();
    test_bad_header();
    test_optional_fields();
    test_long_extra();
    test_random_members();
    in_valid <= 1'b0;
    rx_idle_en = 1'b1;
    repeat (4000) begin
      if (status_q.size() == 0) break;
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    leftover = status_q.size();
    if (leftover != 0) $display("%0d expected beats never came out", leftover);
    $display("%0d byte beats over %0d members/runs, %0d results checked", n_beats, n_members,
             n_results);
    $display("done %0d, body %0d, magic %0d, method %0d, hcrc %0d; %0d mismatches, %0d extra",
             seen[ST_DONE], seen[ST_BODY], seen[ST_MAGIC], seen[ST_METHOD], seen[ST_CRC],
             n_mismatch, n_unexpected);
    if (n_mismatch == 0 && n_unexpected == 0 && leftover == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule
